### hw/rtl/csv_integer_field_parser_top_macros.svh
// Assertion macros shared by the CSV integer field parser modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CSV_INTEGER_FIELD_PARSER_TOP_MACROS_SVH
`define CSV_INTEGER_FIELD_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define CIFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define CIFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

### hw/rtl/cifp_pkg.sv
// Types and constants of the CSV integer field parser.
// No dependencies; used by every other file of the block except the assertion macro header.
package cifp_pkg;

   localparam int DIGIT_LIMIT  = 9;
   localparam int COLUMN_BOUND = 1023;
   localparam int ROW_BOUND    = 65535;

   localparam int COL_W   = 10;
   localparam int ROW_W   = 16;
   localparam int VALUE_W = 30;
   localparam int DIGIT_W = 4;

   localparam logic [COL_W-1:0] COL_CAP =
      COL_W'((COLUMN_BOUND < 1023) ? COLUMN_BOUND : 1023);
   localparam logic [ROW_W-1:0] ROW_CAP =
      ROW_W'((ROW_BOUND < 65535) ? ROW_BOUND : 65535);
   localparam logic [VALUE_W-1:0] CELL_MAX = VALUE_W'(999999999);
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(DIGIT_LIMIT);

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      KIND_CELL  = 2'd0,
      KIND_DIMS  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_CHAR  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_RANGE = 2'd2
   } error_type;

   typedef struct packed {
      kind_type             record_kind;
      logic [VALUE_W-1:0]   cell_value;
      logic [COL_W-1:0]     column_count;
      logic [ROW_W-1:0]     row_count;
      error_type            error_code;
      logic                 last_of_file;
   } record_type;

   typedef struct packed {
      logic [1:0]  count;
      record_type  first;
      record_type  second;
   } push_type;

   typedef struct packed {
      logic [COL_W-1:0] min_columns;
      logic [COL_W-1:0] max_columns;
      logic [ROW_W-1:0] min_rows;
      logic [ROW_W-1:0] max_rows;
   } limits_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

endpackage

### hw/rtl/cifp_if.sv
// Valid/ready channel interfaces for text input beats and result beats.
// Depends on cifp_pkg.
interface cifp_req_if import cifp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface cifp_rsp_if import cifp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         record_kind;
   logic [VALUE_W-1:0] cell_value;
   logic [COL_W-1:0]   column_count;
   logic [ROW_W-1:0]   row_count;
   logic [1:0]         error_code;
   logic               last_of_file;

   modport source (output valid, output record_kind, output cell_value,
                   output column_count, output row_count, output error_code,
                   output last_of_file, input ready);
   modport sink (input valid, input record_kind, input cell_value,
                 input column_count, input row_count, input error_code,
                 input last_of_file, output ready);
endinterface

### hw/rtl/cifp_csr.sv
// APB-style limit registers of the CSV integer field parser.
// Depends on cifp_pkg.
module cifp_csr import cifp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output limits_type  limits
);

   typedef enum logic [1:0] {
      REG_MIN_COLUMNS = 2'd0,
      REG_MAX_COLUMNS = 2'd1,
      REG_MIN_ROWS    = 2'd2,
      REG_MAX_ROWS    = 2'd3
   } reg_index_type;

   limits_type    limits_ff;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[3:2]);
   assign write_en = psel & penable & pwrite;
   assign limits   = limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.min_columns <= COL_W'(1);
         limits_ff.max_columns <= COL_W'(1023);
         limits_ff.min_rows    <= ROW_W'(1);
         limits_ff.max_rows    <= ROW_W'(65535);
      end else if (write_en) begin
         unique case (index)
            REG_MIN_COLUMNS: limits_ff.min_columns <= pwdata[COL_W-1:0];
            REG_MAX_COLUMNS: limits_ff.max_columns <= pwdata[COL_W-1:0];
            REG_MIN_ROWS:    limits_ff.min_rows    <= pwdata[ROW_W-1:0];
            REG_MAX_ROWS:    limits_ff.max_rows    <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MIN_COLUMNS: prdata = 32'(limits_ff.min_columns);
         REG_MAX_COLUMNS: prdata = 32'(limits_ff.max_columns);
         REG_MIN_ROWS:    prdata = 32'(limits_ff.min_rows);
         REG_MAX_ROWS:    prdata = 32'(limits_ff.max_rows);
         default:         prdata = 32'd0;
      endcase
   end

endmodule

### hw/rtl/cifp_core.sv
// Parse state and record generation: one text beat per cycle while accept is high.
// Depends on cifp_pkg and the assertion macro header.
`include "csv_integer_field_parser_top_macros.svh"
module cifp_core import cifp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  text_char,
   input  logic        end_of_text,
   input  limits_type  limits,
   output push_type    push
);

   logic               on_first_line_ff, on_first_line_in;
   logic               after_digit_ff, after_digit_in;
   logic               after_newline_ff, after_newline_in;
   logic               failed_ff, failed_in;
   logic [COL_W-1:0]   columns_seen_ff, columns_seen_in;
   logic [ROW_W-1:0]   rows_seen_ff, rows_seen_in;
   logic [DIGIT_W-1:0] digits_taken_ff, digits_taken_in;
   logic [VALUE_W-1:0] value_accum_ff, value_accum_in;

   logic               is_digit, is_sep, is_lf, is_cr;
   logic               col_inc, row_inc;
   logic [COL_W-1:0]   cols_cell, cols_close;
   logic [ROW_W-1:0]   rows_close;
   logic [VALUE_W+3:0] times_ten;
   logic               out_of_range;
   record_type         cell_rec, err_rec;
   logic               end_beat, silent_beat, cleared;

   assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
   assign is_sep   = (text_char == CHAR_SEMI) || (text_char == CHAR_COMMA);
   assign is_lf    = (text_char == CHAR_LF);
   assign is_cr    = (text_char == CHAR_CR);

   assign col_inc    = on_first_line_ff && (columns_seen_ff < COL_CAP);
   assign row_inc    = !after_newline_ff && (rows_seen_ff < ROW_CAP);
   assign cols_cell  = columns_seen_ff + COL_W'(col_inc);
   assign cols_close = columns_seen_ff + COL_W'(col_inc && after_digit_ff);
   assign rows_close = rows_seen_ff + ROW_W'(row_inc);

   assign times_ten = ({4'd0, value_accum_ff} << 3) + ({4'd0, value_accum_ff} << 1)
                    + (VALUE_W+4)'(text_char[3:0]);

   assign out_of_range = (cols_close < limits.min_columns) ||
                         (cols_close > limits.max_columns) ||
                         (rows_close < limits.min_rows) ||
                         (rows_close > limits.max_rows);

   assign end_beat    = accept && end_of_text;
   assign silent_beat = accept && failed_ff && !end_of_text;
   assign cleared     = !failed_ff && on_first_line_ff &&
                        (columns_seen_ff == '0) && (rows_seen_ff == '0);

   always_comb begin
      cell_rec              = '0;
      cell_rec.record_kind  = KIND_CELL;
      cell_rec.error_code   = ERR_CHAR;
      cell_rec.cell_value   = value_accum_ff;
      cell_rec.column_count = cols_close;
      cell_rec.row_count    = rows_close;
      err_rec               = '0;
      err_rec.record_kind   = KIND_ERROR;
      err_rec.error_code    = ERR_CHAR;
      err_rec.column_count  = columns_seen_ff;
      err_rec.row_count     = rows_seen_ff;
      err_rec.last_of_file  = 1'b1;

      on_first_line_in = on_first_line_ff;
      after_digit_in   = after_digit_ff;
      after_newline_in = after_newline_ff;
      failed_in        = failed_ff;
      columns_seen_in  = columns_seen_ff;
      rows_seen_in     = rows_seen_ff;
      digits_taken_in  = digits_taken_ff;
      value_accum_in   = value_accum_ff;
      push             = '0;
      push.first       = cell_rec;
      push.second      = err_rec;

      if (accept) begin
         if (end_of_text) begin
            if (!failed_ff) begin
               push.second.column_count = cols_close;
               push.second.row_count    = rows_close;
               if (out_of_range) begin
                  push.second.error_code = ERR_RANGE;
               end else begin
                  push.second.record_kind = KIND_DIMS;
               end
               if (after_digit_ff) begin
                  push.count = 2'd2;
               end else begin
                  push.count = 2'd1;
                  push.first = push.second;
               end
            end
            on_first_line_in = 1'b1;
            after_digit_in   = 1'b0;
            after_newline_in = 1'b0;
            failed_in        = 1'b0;
            columns_seen_in  = '0;
            rows_seen_in     = '0;
            digits_taken_in  = '0;
            value_accum_in   = '0;
         end else if (!failed_ff) begin
            if (is_digit) begin
               if (digits_taken_ff < DIGIT_MAX) begin
                  value_accum_in  = (times_ten > (VALUE_W+4)'(CELL_MAX)) ?
                                    CELL_MAX : times_ten[VALUE_W-1:0];
                  digits_taken_in = digits_taken_ff + DIGIT_W'(1);
               end
               after_digit_in   = 1'b1;
               after_newline_in = 1'b0;
            end else if (is_sep) begin
               if (!after_digit_ff) begin
                  failed_in              = 1'b1;
                  push.count             = 2'd1;
                  push.first             = err_rec;
                  push.first.error_code  = ERR_EMPTY;
               end else begin
                  columns_seen_in         = cols_cell;
                  push.count              = 2'd1;
                  push.first.column_count = cols_cell;
                  push.first.row_count    = rows_seen_ff;
                  after_digit_in          = 1'b0;
                  after_newline_in        = 1'b0;
                  value_accum_in          = '0;
                  digits_taken_in         = '0;
               end
            end else if (is_lf) begin
               rows_seen_in     = rows_close;
               columns_seen_in  = cols_close;
               after_newline_in = 1'b1;
               after_digit_in   = 1'b0;
               on_first_line_in = 1'b0;
               value_accum_in   = '0;
               digits_taken_in  = '0;
               push.count       = 2'(after_digit_ff);
            end else if (!is_cr) begin
               failed_in  = 1'b1;
               push.count = 2'd1;
               push.first = err_rec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_first_line_ff <= 1'b1;
         after_digit_ff   <= 1'b0;
         after_newline_ff <= 1'b0;
         failed_ff        <= 1'b0;
         columns_seen_ff  <= '0;
         rows_seen_ff     <= '0;
         digits_taken_ff  <= '0;
         value_accum_ff   <= '0;
      end else begin
         on_first_line_ff <= on_first_line_in;
         after_digit_ff   <= after_digit_in;
         after_newline_ff <= after_newline_in;
         failed_ff        <= failed_in;
         columns_seen_ff  <= columns_seen_in;
         rows_seen_ff     <= rows_seen_in;
         digits_taken_ff  <= digits_taken_in;
         value_accum_ff   <= value_accum_in;
      end
   end

   `CIFP_ASSERT_NEXT(a_end_rearms, clock, reset, end_beat, cleared)
   `CIFP_ASSERT_NOW(a_failed_silent, clock, reset, silent_beat, push.count == 2'd0)
   `CIFP_ASSERT_NOW(a_pair_only_at_end, clock, reset, push.count == 2'd2, end_beat)

endmodule

### hw/rtl/cifp_outq.sv
// Result record queue: takes up to two records per cycle, sends one per beat.
// Depends on cifp_pkg and the assertion macro header.
`include "csv_integer_field_parser_top_macros.svh"
module cifp_outq import cifp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output record_type out_record
);

   record_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;
   logic             pushing, pop_only;
   logic [3:0]       fill_after;
   logic [PTR_W-1:0] ptr_gap;

   assign room       = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign out_valid  = count_ff != '0;
   assign out_record = entries_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;
   assign wr_next    = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   assign count_in   = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   assign pushing    = push.count != 2'd0;
   assign pop_only   = pop && !pushing;
   assign fill_after = 4'(count_ff) + 4'(push.count);
   assign ptr_gap    = wr_ptr_ff - rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CIFP_ASSERT_NOW(a_no_overflow, clock, reset, pushing, fill_after <= 4'(QUEUE_DEPTH))
   `CIFP_ASSERT_NEXT(a_drain_step, clock, reset, pop_only, count_ff == $past(count_ff) - CNT_W'(1))
   `CIFP_ASSERT_NOW(a_ptr_track, clock, reset, 1'b1, ptr_gap == count_ff[PTR_W-1:0])

endmodule

### hw/rtl/csv_integer_field_parser_top.sv
// CSV integer field parser. Takes one text byte per beat on req_bus and
// returns cell values, final dimensions or an error on rsp_bus via the
// four-entry result queue. An input beat is taken every cycle while the queue
// holds at most two records. The end-of-text beat, which can yield a cell
// record and a final record, is taken like any other, and the input then waits
// until the queue is back to two records. The user must write the limits over
// the APB-style port at offsets 0x0, 0x4, 0x8, 0xC (min/max columns, min/max
// rows) only while the block is idle; the block itself does not enforce this.
module csv_integer_field_parser_top import cifp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cifp_req_if.sink    req_bus,
   cifp_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   limits_type limits;
   push_type   push;
   record_type out_record;
   logic       room;
   logic       accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   cifp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   cifp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_char   (req_bus.text_char),
      .end_of_text (req_bus.end_of_text),
      .limits      (limits),
      .push        (push)
   );

   cifp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_record (out_record)
   );

   assign rsp_bus.record_kind  = out_record.record_kind;
   assign rsp_bus.cell_value   = out_record.cell_value;
   assign rsp_bus.column_count = out_record.column_count;
   assign rsp_bus.row_count    = out_record.row_count;
   assign rsp_bus.error_code   = out_record.error_code;
   assign rsp_bus.last_of_file = out_record.last_of_file;

endmodule

### verif/cifp_tb_pkg.sv
// Register map of the parser's configuration port, shared by the testbench files.
// No dependencies; used by the stimulus top and the checker.
package cifp_tb_pkg;

   typedef enum logic [1:0] {
      REG_MIN_COLUMNS = 2'd0,
      REG_MAX_COLUMNS = 2'd1,
      REG_MIN_ROWS    = 2'd2,
      REG_MAX_ROWS    = 2'd3
   } csr_index_type;

endpackage

### verif/cifp_parse_monitor.sv
// Checker for the CSV integer field parser: follows limit writes and text beats, parses
// the text itself and compares every result beat with the oldest record it predicted.
// Depends on cifp_pkg, cifp_tb_pkg and the channel interfaces of cifp_if.sv.
module cifp_parse_monitor import cifp_pkg::*, cifp_tb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cifp_req_if         req_mon,
   cifp_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        closing,
   output int          pending,
   output int          failures,
   output int          records_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   limits_type limits;

   bit first_line, in_cell, line_ended, aborted, closed;
   logic [COL_W-1:0]   col_total;
   logic [ROW_W-1:0]   row_total;
   logic [DIGIT_W-1:0] digit_count;
   logic [VALUE_W-1:0] accum;

   record_type expected_records[$];

   initial begin
      pending = 0;
      failures = 0;
      records_checked = 0;
      closed = 1'b0;
   end

   function automatic void restart_parse();
      first_line  = 1'b1;
      in_cell     = 1'b0;
      line_ended  = 1'b0;
      aborted     = 1'b0;
      col_total   = '0;
      row_total   = '0;
      digit_count = '0;
      accum       = '0;
   endfunction

   function automatic void push_record(kind_type kind, logic [VALUE_W-1:0] value,
                                       error_type code, logic last);
      record_type r;
      r.record_kind  = kind;
      r.cell_value   = value;
      r.column_count = col_total;
      r.row_count    = row_total;
      r.error_code   = code;
      r.last_of_file = last;
      expected_records.push_back(r);
   endfunction

   function automatic void bump_column();
      if (first_line && col_total < COL_CAP) col_total++;
   endfunction

   function automatic void bump_row();
      if (!line_ended && row_total < ROW_CAP) row_total++;
   endfunction

   function automatic void parse_text_beat(logic [7:0] ch, logic eot);
      bit                 had_digit;
      logic [VALUE_W-1:0] held;
      longint             grown;
      had_digit = in_cell;
      held = accum;
      if (eot) begin
         if (!aborted) begin
            bump_row();
            if (had_digit) begin
               bump_column();
               push_record(KIND_CELL, held, ERR_CHAR, 1'b0);
            end
            if (col_total < limits.min_columns || col_total > limits.max_columns ||
                row_total < limits.min_rows || row_total > limits.max_rows)
               push_record(KIND_ERROR, '0, ERR_RANGE, 1'b1);
            else
               push_record(KIND_DIMS, '0, ERR_CHAR, 1'b1);
         end
         restart_parse();
      end else if (aborted) begin
         // rest of a failed file is dropped
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         if (digit_count < DIGIT_MAX) begin
            grown = longint'(accum) * 10 + longint'(ch - CHAR_ZERO);
            accum = (grown > longint'(CELL_MAX)) ? CELL_MAX : VALUE_W'(grown);
            digit_count++;
         end
         in_cell = 1'b1;
         line_ended = 1'b0;
      end else if (ch == CHAR_SEMI || ch == CHAR_COMMA) begin
         if (!had_digit) begin
            aborted = 1'b1;
            push_record(KIND_ERROR, '0, ERR_EMPTY, 1'b1);
         end else begin
            bump_column();
            push_record(KIND_CELL, held, ERR_CHAR, 1'b0);
            in_cell = 1'b0;
            line_ended = 1'b0;
            accum = '0;
            digit_count = '0;
         end
      end else if (ch == CHAR_LF) begin
         bump_row();
         if (had_digit) bump_column();
         line_ended = 1'b1;
         in_cell = 1'b0;
         first_line = 1'b0;
         accum = '0;
         digit_count = '0;
         if (had_digit) push_record(KIND_CELL, held, ERR_CHAR, 1'b0);
      end else if (ch == CHAR_CR) begin
         // skipped
      end else begin
         aborted = 1'b1;
         push_record(KIND_ERROR, '0, ERR_CHAR, 1'b1);
      end
   endfunction

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      record_type want;
      if (reset) begin
         limits = '{min_columns: 10'd1, max_columns: 10'd1023,
                    min_rows: 16'd1, max_rows: 16'd65535};
         restart_parse();
         expected_records.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[3:2]))
               REG_MIN_COLUMNS: limits.min_columns = pwdata[COL_W-1:0];
               REG_MAX_COLUMNS: limits.max_columns = pwdata[COL_W-1:0];
               REG_MIN_ROWS:    limits.min_rows    = pwdata[ROW_W-1:0];
               REG_MAX_ROWS:    limits.max_rows    = pwdata[ROW_W-1:0];
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            parse_text_beat(req_mon.text_char, req_mon.end_of_text);
         if (rsp_mon.valid && rsp_mon.ready) begin
            records_checked++;
            if (expected_records.size() == 0) begin
               $error("result beat with no record expected: kind %0d value %0d",
                      rsp_mon.record_kind, rsp_mon.cell_value);
               failures++;
            end else begin
               want = expected_records.pop_front();
               check_field("record_kind", want.record_kind, rsp_mon.record_kind);
               check_field("cell_value", want.cell_value, rsp_mon.cell_value);
               check_field("column_count", want.column_count, rsp_mon.column_count);
               check_field("row_count", want.row_count, rsp_mon.row_count);
               check_field("error_code", want.error_code, rsp_mon.error_code);
               check_field("last_of_file", want.last_of_file, rsp_mon.last_of_file);
            end
         end
         if (closing && !closed) begin
            closed = 1'b1;
            if (expected_records.size() != 0) begin
               $error("%0d expected records never arrived", expected_records.size());
               failures++;
            end
         end
      end
      pending <= expected_records.size();
   end

endmodule

### verif/tb.sv
// Testbench top for the CSV integer field parser: drives text beats, limit writes
// and result back-pressure, and reports the verdict from the checker's failure count.
// Depends on cifp_pkg, cifp_tb_pkg, cifp_if.sv, cifp_parse_monitor and the RTL top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cifp_pkg::*;
   import cifp_tb_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   logic        clock, reset;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        closing;
   int          pending, failures, records_checked;
   int unsigned cycle_count;

   bit calm, hold_go, hold_done;
   int beats_sent, files_sent;
   int settings_used = 1;

   cifp_req_if req_if ();
   cifp_rsp_if rsp_if ();

   csv_integer_field_parser_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cifp_parse_monitor watch (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .closing         (closing),
      .pending         (pending),
      .failures        (failures),
      .records_checked (records_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** csv_integer_field_parser_top: FAILED **");
      $finish;
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 28);
         end
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic eot);
      while (!calm && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.text_char   <= ch;
      req_if.end_of_text <= eot;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   function automatic logic [7:0] sep_char();
      return $urandom_range(1) ? CHAR_COMMA : CHAR_SEMI;
   endfunction

   task automatic send_digits();
      int len;
      len = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
      repeat (len) send_beat(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
   endtask

   // empty cell or a byte outside the CSV alphabet
   task automatic send_defect();
      logic [7:0] b;
      if ($urandom_range(1)) begin
         send_beat(sep_char(), 1'b0);
      end else begin
         do b = 8'($urandom_range(255));
         while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SEMI || b == CHAR_COMMA ||
                b == CHAR_LF || b == CHAR_CR);
         send_beat(b, 1'b0);
      end
   endtask

   task automatic send_file(input int cols, input int rows, input bit spoil);
      int spoil_at, cell_idx;
      spoil_at = (spoil && rows > 0) ? $urandom_range(cols * rows - 1) : -1;
      cell_idx = 0;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if (cell_idx == spoil_at) send_defect();
            send_digits();
            cell_idx++;
            if (c < cols - 1 || $urandom_range(4) == 0) send_beat(sep_char(), 1'b0);
         end
         if (r < rows - 1 || $urandom_range(1)) begin
            if ($urandom_range(2) == 0) send_beat(CHAR_CR, 1'b0);
            send_beat(CHAR_LF, 1'b0);
            if ($urandom_range(5) == 0) send_beat(CHAR_LF, 1'b0);
         end
      end
      send_end();
      files_sent++;
   endtask

   task automatic send_noise();
      int         len;
      logic [7:0] b;
      len = $urandom_range(12, 1);
      repeat (len) begin
         case ($urandom_range(9))
            0, 1, 2, 3: b = CHAR_ZERO + 8'($urandom_range(9));
            4:          b = CHAR_COMMA;
            5:          b = CHAR_SEMI;
            6:          b = CHAR_LF;
            7:          b = CHAR_CR;
            default:    b = 8'($urandom_range(255));
         endcase
         send_beat(b, 1'b0);
      end
      send_end();
      files_sent++;
   endtask

   task automatic run_phase(input int budget, input int cols_lo, input int cols_hi,
                            input int rows_hi);
      int stop_at, pick;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 85)
            send_file($urandom_range(cols_hi, cols_lo), $urandom_range(rows_hi), pick >= 70);
         else
            send_noise();
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_limits(input int min_cols, input int max_cols,
                             input int min_rows, input int max_rows);
      wait_drained();
      csr_write(REG_MIN_COLUMNS, min_cols);
      csr_write(REG_MAX_COLUMNS, max_cols);
      csr_write(REG_MIN_ROWS, min_rows);
      csr_write(REG_MAX_ROWS, max_rows);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.text_char   <= '0;
      req_if.end_of_text <= 1'b0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      closing            <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty text, long and zero-led cells, trailing separator, blank lines, CR, empty cell, bad byte
      send_end();
      send_text("00123456789,9;\n\n5\r");
      send_end();
      send_text(";");
      send_end();
      send_beat(8'hFF, 1'b0);
      send_text("1");
      send_end();

      run_phase(250, 1, 5, 5);

      set_limits(0, 1023, 0, 65535);
      hold_go = 1'b1;
      run_phase(250, 1, 6, 6);

      set_limits(3, 3, 2, 4);
      calm = 1'b1;
      run_phase(300, 2, 4, 6);
      calm = 1'b0;

      set_limits(1023, 0, 65535, 0);
      run_phase(100, 1, 4, 4);

      repeat (3) begin
         set_limits($urandom_range(3), $urandom_range(6, 2), $urandom_range(3),
                    $urandom_range(6, 1));
         run_phase(120, 1, 5, 6);
      end

      wait_drained();
      closing <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d text beats in %0d files under %0d limit settings;",
               beats_sent, files_sent, settings_used);
      $display("compared %0d result records, with one long result stall.", records_checked);
      if (failures == 0)
         $display("** csv_integer_field_parser_top: PASSED **");
      else
         $display("** csv_integer_field_parser_top: FAILED **");
      $finish;
   end

endmodule
